>>> src/sorted_insert_queue_assert.svh
// Assertion macros shared by the sorted insert queue RTL.
`ifndef SORTED_INSERT_QUEUE_ASSERT_SVH
`define SORTED_INSERT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted insert queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted insert queue: next-cycle check failed");

`endif

>>> src/siq_pkg.sv
// Types and constants shared by the sorted insert queue modules.
package siq_pkg;

  localparam int VAL_W = 32;
  localparam int OCC_W = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    last;
    logic                    empty_store;
    logic                    refused;
    logic [OCC_W-1:0]        occupancy;
  } out_word_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                    insert_en;
    logic                    rotate_en;
    logic signed [VAL_W-1:0] value;
  } siq_ctrl_t;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic occupied;
    logic tail;
  } siq_pos_t;

endpackage

>>> src/siq_cell.sv
// One storage cell of the sorted chain: compare, shift up on insert, rotate on dump.
module siq_cell (
  input  logic                             clk,
  input  siq_pkg::siq_ctrl_t               ctrl,
  input  siq_pkg::siq_pos_t                pos,
  input  logic                             left_less,
  input  logic signed [siq_pkg::VAL_W-1:0] left_value,
  input  logic signed [siq_pkg::VAL_W-1:0] right_value,
  input  logic signed [siq_pkg::VAL_W-1:0] head_value,
  output logic                             less_o,
  output logic signed [siq_pkg::VAL_W-1:0] value_o
);
  import siq_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;

  // A cell holding a smaller value keeps it; the first cell that does not
  // takes the new value and every cell above it takes its left neighbor's.
  assign less_o  = pos.occupied && (entry_r < ctrl.value);
  assign value_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert_en) begin
      if (!less_o) begin
        entry_nxt = left_less ? ctrl.value : left_value;
      end
    end else if (ctrl.rotate_en && pos.occupied) begin
      // The last occupied cell wraps around to the head value.
      entry_nxt = pos.tail ? head_value : right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> src/sorted_insert_queue.sv
// Sorted insert queue: an ascending store of signed words built as a chain of cells.
// An insert gives a single result word, which is registered at the
// accepting edge and offered in the cycle after it.
// A dump of N stored words streams one word per cycle while out_stall is low;
// an empty dump gives one word.
// The rate is set by the dump, which rotates the cell chain by one place per word.
// Synchronous active-low reset empties the store; cell contents are not cleared.
`include "sorted_insert_queue_assert.svh"

module sorted_insert_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  siq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output siq_pkg::out_word_t out_word
);
  import siq_pkg::*;

  // Count width holds CAPACITY itself; the dump index only needs CAPACITY-1.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic            state_r;
  logic            state_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [KW-1:0]   idx_r;
  logic [KW-1:0]   idx_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  out_word_t       out_word_r;
  out_word_t       out_word_nxt;

  logic            out_free;
  logic            in_fire;
  logic            full;
  logic            insert_go;
  logic            dump_start;
  logic            dump_step;
  logic            rotate;
  logic [KW-1:0]   idx_cur;
  logic            last_emit;
  siq_ctrl_t       ctrl;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     cell_less;
  logic signed [VAL_W-1:0] head_val;

  // The output register is free when it is empty or its word leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // No new word is taken while a dump streams or the output register is held.
  assign in_stall = (state_r == ST_DUMP) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign full       = (count_r == CW'(CAPACITY));
  assign insert_go  = in_fire && (in_word.kind == KIND_INSERT) && !full;
  assign dump_start = in_fire && (in_word.kind == KIND_DUMP) && (count_r != '0);
  assign dump_step  = (state_r == ST_DUMP) && out_free;
  assign rotate     = dump_start || dump_step;

  // The head cell always holds the next word of a dump, since the chain
  // rotates left by one place for every word sent out.
  assign idx_cur   = dump_start ? '0 : idx_r;
  assign last_emit = (CW'(idx_cur) == (count_r - 1'b1));
  assign head_val  = cell_val[0];

  assign ctrl.insert_en = insert_go;
  assign ctrl.rotate_en = rotate;
  assign ctrl.value     = in_word.value;

  // Chain of cells: each one sees its left neighbor's compare result and value,
  // its right neighbor's value for rotation, and the head value for wrap-around.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    siq_pos_t                pos;
    logic                    left_less;
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;

    assign pos.occupied = (CW'(i) < count_r);
    assign pos.tail     = (CW'(i) == (count_r - 1'b1));

    if (i == 0) begin : g_first
      assign left_less  = 1'b1;
      assign left_value = in_word.value;
    end else begin : g_inner
      assign left_less  = cell_less[i-1];
      assign left_value = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = head_val;
    end else begin : g_mid
      assign right_value = cell_val[i+1];
    end

    siq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos),
      .left_less   (left_less),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (head_val),
      .less_o      (cell_less[i]),
      .value_o     (cell_val[i])
    );
  end

  // Sequencer for the dump stream and the fill count.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = insert_go ? count_r + 1'b1 : count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (dump_start && !last_emit) begin
          state_nxt = ST_DUMP;
          idx_nxt   = KW'(1);
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          if (last_emit) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result word: one per insert or empty dump, one per stored value otherwise.
  always_comb begin
    out_word_nxt             = out_word_r;
    out_word_nxt.value_res   = '0;
    out_word_nxt.last        = 1'b1;
    out_word_nxt.empty_store = 1'b0;
    out_word_nxt.refused     = 1'b0;
    if (rotate) begin
      out_word_nxt.value_res = head_val;
      out_word_nxt.last      = last_emit;
      out_word_nxt.occupancy = OCC_W'(count_r);
    end else if (in_word.kind == KIND_INSERT) begin
      out_word_nxt.refused   = full;
      out_word_nxt.occupancy = full ? OCC_W'(count_r) : OCC_W'(count_r + 1'b1);
    end else begin
      out_word_nxt.empty_store = 1'b1;
      out_word_nxt.occupancy   = '0;
    end
    if (!(in_fire || dump_step)) begin
      out_word_nxt = out_word_r;
    end
  end

  assign out_valid_nxt = (in_fire || dump_step) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The fill count never passes the capacity.
  `SIQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  // A dump in progress always has stored words and an index inside them.
  `SIQ_ASSERT_NOW(a_dump_index, state_r == ST_DUMP, (count_r != '0) && (CW'(idx_r) < count_r))
  // The store does not change size while a dump streams.
  `SIQ_ASSERT_NEXT(a_dump_count_stable, state_r == ST_DUMP, $stable(count_r))
  // A refused insert reports a full store.
  `SIQ_ASSERT_NOW(a_refused_full, out_valid_r && out_word_r.refused, full)

endmodule
